### design/fpcd_pkg.sv
// shared types, codes and the crc-16 byte update for the packet deframer
package fpcd_pkg;

	// parser phase codes
	localparam logic [2:0] PH_SOF0    = 3'd0;
	localparam logic [2:0] PH_SOF1    = 3'd1;
	localparam logic [2:0] PH_HEADER  = 3'd2;
	localparam logic [2:0] PH_PAYLOAD = 3'd3;
	localparam logic [2:0] PH_CRC0    = 3'd4;
	localparam logic [2:0] PH_CRC1    = 3'd5;

	// event codes reported per byte
	localparam logic [2:0] EV_UNCLAIMED = 3'd0;
	localparam logic [2:0] EV_CONSUMED  = 3'd1;
	localparam logic [2:0] EV_PAYLOAD   = 3'd2;
	localparam logic [2:0] EV_GOOD      = 3'd3;
	localparam logic [2:0] EV_CRC_BAD   = 3'd4;
	localparam logic [2:0] EV_LEN_BAD   = 3'd5;

	localparam logic [7:0]  START_A       = 8'hA5;
	localparam logic [7:0]  START_B       = 8'h5A;
	localparam logic [15:0] CRC_POLY      = 16'hA001;
	localparam logic [15:0] CRC_INIT      = 16'hFFFF;
	localparam logic [15:0] MAX_LEN_RESET = 16'd256;
	localparam int          HDR_BYTES     = 6;
	localparam logic [2:0]  HDR_LAST      = 3'd5;
	localparam logic [2:0]  HDR_FULL      = 3'd6;

	// byte held in the input register
	typedef struct packed {
		logic       valid;
		logic [7:0] rx_byte;
	} byte_req_t;

	// reflected crc-16/modbus, one byte, eight bit steps
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'd0, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

### design/fpcd_in_stage.sv
// input register that holds one received byte until the parser takes it
module fpcd_in_stage import fpcd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic [7:0] rx_byte,
	input  logic      take,
	output byte_req_t req_s1
);

	logic       valid_s1;
	logic [7:0] byte_s1;

	// free when empty or when the held byte leaves this cycle
	assign in_ready = !valid_s1 || take;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// byte payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	assign req_s1.valid   = valid_s1;
	assign req_s1.rx_byte = byte_s1;

endmodule

### design/fpcd_parser.sv
// frame parser state, crc check and result register
module fpcd_parser import fpcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  byte_req_t   req_s1,
	output logic        take,
	input  logic [15:0] max_len,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_res,
	output logic [7:0]  frame_version,
	output logic [7:0]  frame_type,
	output logic [15:0] frame_sequence,
	output logic [15:0] frame_length,
	output logic [7:0]  data_byte,
	output logic [15:0] data_index,
	output logic        last_payload
);

	logic [2:0]  phase_q, phase_d;
	logic [2:0]  hcnt_q, hcnt_d;
	logic [7:0]  hdr_q [HDR_BYTES];
	logic [7:0]  hdr_d [HDR_BYTES];
	logic [15:0] pcnt_q, pcnt_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  rxcrc_lo_q, rxcrc_lo_d;

	logic [2:0]  ev_d;
	logic [7:0]  dbyte_d;
	logic [15:0] didx_d;
	logic        last_d;

	logic [7:0]  b;
	logic [15:0] crc_upd;
	logic [2:0]  hidx;
	logic [16:0] pcnt_inc;
	logic [15:0] new_len;
	logic [15:0] cur_len;

	logic [2:0]  ev_q;
	logic [7:0]  dbyte_q;
	logic [15:0] didx_q;
	logic        last_q;
	logic        ovalid_q;

	// one byte moves through when the result slot is free
	assign take = req_s1.valid && (!ovalid_q || out_ready);

	assign b        = req_s1.rx_byte;
	assign crc_upd  = crc16_byte(crc_q, b);
	assign hidx     = (hcnt_q >= HDR_FULL) ? 3'd0 : hcnt_q;
	assign pcnt_inc = {1'b0, pcnt_q} + 17'd1;
	assign new_len  = {b, hdr_q[4]};
	assign cur_len  = {hdr_q[5], hdr_q[4]};

	// next state and result for the byte in the input register
	always_comb begin
		phase_d    = phase_q;
		hcnt_d     = hcnt_q;
		hdr_d      = hdr_q;
		pcnt_d     = pcnt_q;
		crc_d      = crc_q;
		rxcrc_lo_d = rxcrc_lo_q;
		ev_d       = EV_CONSUMED;
		dbyte_d    = 8'd0;
		didx_d     = 16'd0;
		last_d     = 1'b0;
		unique case (phase_q)
			PH_SOF0: begin
				if (b == START_A) begin
					phase_d    = PH_SOF1;
					hcnt_d     = 3'd0;
					pcnt_d     = 16'd0;
					rxcrc_lo_d = 8'd0;
					crc_d      = CRC_INIT;
				end else begin
					ev_d = EV_UNCLAIMED;
				end
			end
			PH_SOF1: begin
				if (b == START_B) begin
					phase_d = PH_HEADER;
				end else begin
					phase_d    = PH_SOF0;
					hcnt_d     = 3'd0;
					pcnt_d     = 16'd0;
					rxcrc_lo_d = 8'd0;
					crc_d      = CRC_INIT;
				end
			end
			PH_HEADER: begin
				hdr_d[hidx] = b;
				hcnt_d      = hidx + 3'd1;
				crc_d       = crc_upd;
				if (hidx == HDR_LAST) begin
					if (new_len > max_len) begin
						// length over the limit drops the frame
						ev_d       = EV_LEN_BAD;
						phase_d    = PH_SOF0;
						hcnt_d     = 3'd0;
						pcnt_d     = 16'd0;
						rxcrc_lo_d = 8'd0;
						crc_d      = CRC_INIT;
					end else begin
						pcnt_d  = 16'd0;
						phase_d = (new_len == 16'd0) ? PH_CRC0 : PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				ev_d    = EV_PAYLOAD;
				dbyte_d = b;
				didx_d  = pcnt_q;
				crc_d   = crc_upd;
				pcnt_d  = pcnt_inc[15:0];
				if (pcnt_inc >= {1'b0, cur_len}) begin
					last_d  = 1'b1;
					phase_d = PH_CRC0;
				end
			end
			PH_CRC0: begin
				rxcrc_lo_d = b;
				phase_d    = PH_CRC1;
			end
			PH_CRC1: begin
				ev_d       = ({b, rxcrc_lo_q} == crc_q) ? EV_GOOD : EV_CRC_BAD;
				phase_d    = PH_SOF0;
				hcnt_d     = 3'd0;
				pcnt_d     = 16'd0;
				rxcrc_lo_d = 8'd0;
				crc_d      = CRC_INIT;
			end
			default: begin
				// codes with no meaning restart the hunt
				phase_d    = PH_SOF0;
				hcnt_d     = 3'd0;
				pcnt_d     = 16'd0;
				rxcrc_lo_d = 8'd0;
				crc_d      = CRC_INIT;
			end
		endcase
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SOF0;
			hcnt_q     <= 3'd0;
			pcnt_q     <= 16'd0;
			crc_q      <= CRC_INIT;
			rxcrc_lo_q <= 8'd0;
			for (int i = 0; i < HDR_BYTES; i++) begin
				hdr_q[i] <= 8'd0;
			end
		end else if (take) begin
			phase_q    <= phase_d;
			hcnt_q     <= hcnt_d;
			pcnt_q     <= pcnt_d;
			crc_q      <= crc_d;
			rxcrc_lo_q <= rxcrc_lo_d;
			hdr_q      <= hdr_d;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (take) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (take) begin
			ev_q    <= ev_d;
			dbyte_q <= dbyte_d;
			didx_q  <= didx_d;
			last_q  <= last_d;
		end
	end

	// header fields only change when a new result is loaded
	assign out_valid      = ovalid_q;
	assign event_res      = ev_q;
	assign data_byte      = dbyte_q;
	assign data_index     = didx_q;
	assign last_payload   = last_q;
	assign frame_version  = hdr_q[0];
	assign frame_type     = hdr_q[1];
	assign frame_sequence = {hdr_q[3], hdr_q[2]};
	assign frame_length   = {hdr_q[5], hdr_q[4]};

	// frame end events always return to hunting
	a_end_hunts: assert property (@(posedge clk) disable iff (!arst_n)
		take && (ev_d == EV_GOOD || ev_d == EV_CRC_BAD || ev_d == EV_LEN_BAD)
		|=> phase_q == PH_SOF0)
		else $error("parser did not return to hunting after frame end");

	// a payload phase byte shows up as a payload request
	a_payload_ev: assert property (@(posedge clk) disable iff (!arst_n)
		take && phase_q == PH_PAYLOAD |=> out_valid && event_res == EV_PAYLOAD)
		else $error("payload byte not reported as payload");

	// last flag only rides on payload requests
	a_last_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_payload |-> event_res == EV_PAYLOAD)
		else $error("last flag on a non-payload request");

	// data fields are zero outside payload requests
	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res != EV_PAYLOAD |-> data_byte == 8'd0 && data_index == 16'd0)
		else $error("data fields set on a non-payload request");

	// last payload byte moves the parser to the crc bytes
	a_last_to_crc: assert property (@(posedge clk) disable iff (!arst_n)
		take && last_d |=> phase_q == PH_CRC0)
		else $error("parser not waiting for crc after last payload byte");

endmodule

### design/framed_packet_crc16_deframer_core.sv
// framed packet deframer with crc-16/modbus check, top level
// path: a byte is held in the input register, then the parser loads its result into the
//   result register when the result slot is free
// throughput: one byte per cycle while the result side keeps out_ready high
// reset: arst_n clears the valid flags of both registers, the parser hunts for 0xA5,
//   header bytes read zero, the length limit returns to 256
module framed_packet_crc16_deframer_core import fpcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] max_payload_len,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_res,
	output logic [7:0]  frame_version,
	output logic [7:0]  frame_type,
	output logic [15:0] frame_sequence,
	output logic [15:0] frame_length,
	output logic [7:0]  data_byte,
	output logic [15:0] data_index,
	output logic        last_payload
);

	byte_req_t   req_s1;
	logic        take;
	logic [15:0] max_len_q;

	// length limit register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= max_payload_len;
		end
	end

	fpcd_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.take     (take),
		.req_s1   (req_s1)
	);

	fpcd_parser u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_s1         (req_s1),
		.take           (take),
		.max_len        (max_len_q),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.event_res      (event_res),
		.frame_version  (frame_version),
		.frame_type     (frame_type),
		.frame_sequence (frame_sequence),
		.frame_length   (frame_length),
		.data_byte      (data_byte),
		.data_index     (data_index),
		.last_payload   (last_payload)
	);

endmodule

### verif/deframer_checker.sv
`timescale 1ns / 1ps
// result checker for the packet deframer: predicts the event of each byte and compares
module deframer_checker import fpcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] max_payload_len,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  event_res,
	input  logic [7:0]  frame_version,
	input  logic [7:0]  frame_type,
	input  logic [15:0] frame_sequence,
	input  logic [15:0] frame_length,
	input  logic [7:0]  data_byte,
	input  logic [15:0] data_index,
	input  logic        last_payload,
	output int          mismatches,
	output int          outstanding
);

	typedef struct packed {
		logic [2:0]  ev;
		logic [7:0]  version;
		logic [7:0]  ftype;
		logic [15:0] sequence_no;
		logic [15:0] length;
		logic [7:0]  dbyte;
		logic [15:0] didx;
		logic        last;
	} deframe_event_t;

	// predicted parser state
	logic [2:0]  phase;
	logic [2:0]  hdr_cnt;
	logic [7:0]  hdr [6];
	logic [15:0] pay_cnt;
	logic [15:0] crc_acc;
	logic [15:0] crc_rx;
	logic [15:0] len_limit;

	deframe_event_t pending_events[$];
	deframe_event_t got_ev;
	deframe_event_t exp_ev;

	// crc-16/modbus update over one byte, lsb first
	function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] r;
		r = acc ^ {8'h00, b};
		repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		return r;
	endfunction

	function automatic logic [15:0] hdr_len();
		return {hdr[5], hdr[4]};
	endfunction

	// back to hunting, header bytes kept
	function automatic void restart_hunt();
		phase   = PH_SOF0;
		hdr_cnt = 3'd0;
		pay_cnt = 16'd0;
		crc_rx  = 16'd0;
		crc_acc = CRC_INIT;
	endfunction

	// advance the parser by one byte and build its event
	function automatic deframe_event_t deframe_step(input logic [7:0] b);
		deframe_event_t r;
		logic [16:0] next_cnt;
		r = '0;
		r.ev = EV_CONSUMED;
		case (phase)
			PH_SOF0: begin
				if (b == START_A) begin
					restart_hunt();
					phase = PH_SOF1;
				end else begin
					r.ev = EV_UNCLAIMED;
				end
			end
			PH_SOF1: begin
				if (b == START_B) begin
					phase = PH_HEADER;
				end else begin
					restart_hunt();
				end
			end
			PH_HEADER: begin
				if (hdr_cnt >= HDR_FULL) begin
					hdr_cnt = 3'd0;
				end
				hdr[hdr_cnt] = b;
				hdr_cnt = hdr_cnt + 3'd1;
				crc_acc = crc16_next(crc_acc, b);
				if (hdr_cnt >= HDR_FULL) begin
					if (hdr_len() > len_limit) begin
						r.ev = EV_LEN_BAD;
						restart_hunt();
					end else begin
						pay_cnt = 16'd0;
						phase = (hdr_len() == 16'd0) ? PH_CRC0 : PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				r.ev = EV_PAYLOAD;
				r.dbyte = b;
				r.didx = pay_cnt;
				crc_acc = crc16_next(crc_acc, b);
				next_cnt = {1'b0, pay_cnt} + 17'd1;
				if (next_cnt >= {1'b0, hdr_len()}) begin
					r.last = 1'b1;
					phase = PH_CRC0;
				end
				pay_cnt = next_cnt[15:0];
			end
			PH_CRC0: begin
				crc_rx = {8'h00, b};
				phase = PH_CRC1;
			end
			PH_CRC1: begin
				crc_rx = {b, crc_rx[7:0]};
				r.ev = (crc_rx == crc_acc) ? EV_GOOD : EV_CRC_BAD;
				restart_hunt();
			end
			default: begin
				restart_hunt();
			end
		endcase
		r.version = hdr[0];
		r.ftype = hdr[1];
		r.sequence_no = {hdr[3], hdr[2]};
		r.length = {hdr[5], hdr[4]};
		return r;
	endfunction

	// one line per mismatch, printing capped
	task automatic report(input string what, input logic [15:0] got_v, input logic [15:0] exp_v);
		if (mismatches < 40) begin
			$display("%0t mismatch on %s: got %h, expected %h", $time, what, got_v, exp_v);
		end
		mismatches++;
	endtask

	// watch the three channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_limit = MAX_LEN_RESET;
			for (int i = 0; i < HDR_BYTES; i++) begin
				hdr[i] = 8'h00;
			end
			restart_hunt();
			pending_events.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			// compare a result request with the oldest prediction
			if (out_valid && out_ready) begin
				got_ev = '{event_res, frame_version, frame_type, frame_sequence, frame_length,
					data_byte, data_index, last_payload};
				if (pending_events.size() == 0) begin
					report("unexpected result event", {13'd0, event_res}, 16'd0);
				end else begin
					exp_ev = pending_events.pop_front();
					if (got_ev.ev !== exp_ev.ev)
						report("event_res", {13'd0, got_ev.ev}, {13'd0, exp_ev.ev});
					if (got_ev.version !== exp_ev.version)
						report("frame_version", {8'd0, got_ev.version}, {8'd0, exp_ev.version});
					if (got_ev.ftype !== exp_ev.ftype)
						report("frame_type", {8'd0, got_ev.ftype}, {8'd0, exp_ev.ftype});
					if (got_ev.sequence_no !== exp_ev.sequence_no)
						report("frame_sequence", got_ev.sequence_no, exp_ev.sequence_no);
					if (got_ev.length !== exp_ev.length)
						report("frame_length", got_ev.length, exp_ev.length);
					if (got_ev.dbyte !== exp_ev.dbyte)
						report("data_byte", {8'd0, got_ev.dbyte}, {8'd0, exp_ev.dbyte});
					if (got_ev.didx !== exp_ev.didx)
						report("data_index", got_ev.didx, exp_ev.didx);
					if (got_ev.last !== exp_ev.last)
						report("last_payload", {15'd0, got_ev.last}, {15'd0, exp_ev.last});
				end
			end
			// limit register write
			if (cfg_valid && cfg_ready) begin
				len_limit = max_payload_len;
			end
			// byte request enters the prediction
			if (in_valid && in_ready) begin
				pending_events.push_back(deframe_step(rx_byte));
			end
			outstanding <= pending_events.size();
		end
	end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// top of the deframer testbench: clock, reset, byte and limit stimulus, verdict
module tb import fpcd_pkg::*; ();

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] max_payload_len = 16'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  event_res;
	logic [7:0]  frame_version;
	logic [7:0]  frame_type;
	logic [15:0] frame_sequence;
	logic [15:0] frame_length;
	logic [7:0]  data_byte;
	logic [15:0] data_index;
	logic        last_payload;
	int          mismatches;
	int          outstanding;

	bit gaps_on = 1'b1;
	int bytes_sent = 0;
	int cur_limit = int'(MAX_LEN_RESET);

	framed_packet_crc16_deframer_core dut (.*);
	deframer_checker frame_chk (.*);

	always #5 clk = ~clk;

	// result side stalls at random
	always @(posedge clk) begin
		out_ready <= !(gaps_on && $urandom_range(99) < 14);
	end

	// one byte request, with random gaps ahead of it
	task automatic push_byte(input logic [7:0] b);
		while (gaps_on && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	// stop sending and wait until every event has come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_limit(input logic [15:0] v);
		cfg_valid <= 1'b1;
		max_payload_len <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_limit = int'(v);
	endtask

	// start pair, header, payload and crc; stops after the header when too long
	task automatic drive_packet(input int len, input bit bad_crc);
		logic [7:0]  hdr [6];
		logic [15:0] crc;
		logic [7:0]  b;
		hdr[0] = 8'($urandom);
		hdr[1] = 8'($urandom);
		hdr[2] = 8'($urandom);
		hdr[3] = 8'($urandom);
		hdr[4] = len[7:0];
		hdr[5] = len[15:8];
		crc = CRC_INIT;
		push_byte(START_A);
		push_byte(START_B);
		for (int i = 0; i < HDR_BYTES; i++) begin
			crc = crc16_byte(crc, hdr[i]);
			push_byte(hdr[i]);
		end
		if (len > cur_limit) return;
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			crc = crc16_byte(crc, b);
			push_byte(b);
		end
		if (bad_crc) crc = crc ^ (16'd1 << $urandom_range(15));
		push_byte(crc[7:0]);
		push_byte(crc[15:8]);
	endtask

	// mostly short payloads, now and then the limit or a few hundred bytes
	function automatic int pick_len();
		int r;
		int n;
		r = $urandom_range(99);
		if (r < 5) n = cur_limit;
		else if (r < 70) n = $urandom_range(8);
		else if (r < 95) n = $urandom_range(40);
		else n = $urandom_range(300, 100);
		if (n > cur_limit) n = cur_limit;
		if (n > 300) n = 300;
		return n;
	endfunction

	// well-formed frames with random content, plus bad-crc and over-length frames, noise, broken starts and cut headers
	task automatic random_traffic(input int target);
		int pick;
		logic [7:0] b;
		while (bytes_sent < target) begin
			pick = $urandom_range(99);
			if (pick < 62) begin
				drive_packet(pick_len(), 1'b0);
			end else if (pick < 74) begin
				drive_packet(pick_len(), 1'b1);
			end else if (pick < 82 && cur_limit < 65535) begin
				drive_packet(cur_limit + 1 + $urandom_range(65534 - cur_limit), 1'b0);
			end else if (pick < 88) begin
				repeat ($urandom_range(4, 1)) push_byte(8'($urandom));
			end else if (pick < 94) begin
				// start byte followed by a wrong second byte
				b = 8'($urandom);
				if (b == START_B) b = ~b;
				push_byte(START_A);
				push_byte(b);
			end else if (cur_limit < 1000) begin
				// header cut short, the next bytes land in it
				push_byte(START_A);
				push_byte(START_B);
				repeat ($urandom_range(5, 1)) push_byte(8'($urandom));
			end else begin
				drive_packet(pick_len(), 1'b0);
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: noise extremes, wrong second start byte, zero length,
		// length over the limit, bad crc
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(START_A);
		push_byte(START_A);
		drive_packet(0, 1'b0);
		drive_packet(65535, 1'b0);
		drive_packet(1, 1'b1);

		random_traffic(300);
		drain();
		write_limit(16'd0);
		random_traffic(550);
		drain();
		// no gaps on either side for this stretch
		gaps_on = 1'b0;
		write_limit(16'hFFFF);
		random_traffic(800);
		drain();
		gaps_on = 1'b1;
		write_limit(16'd5);
		random_traffic(1050);
		drain();
		write_limit(16'($urandom_range(65535)));
		random_traffic(1300);
		drain();

		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

### sim.f
design/fpcd_pkg.sv
design/fpcd_in_stage.sv
design/fpcd_parser.sv
design/framed_packet_crc16_deframer_core.sv
verif/deframer_checker.sv
verif/tb.sv
